@@ rtl/isort_pkg.sv @@
// ----------------------------------------------------------------------------
// isort_pkg
// shared types and constants for the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // controller states
    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_EMIT = 1'b1
    } isort_state_t;

    // controller to datapath
    typedef struct packed {
        logic insert;   // accept one word into the cell row
        logic pop;      // shift the row down by one, head word consumed
    } isort_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_entry;   // head word is the final one of the set
    } isort_status_t;

endpackage

@@ rtl/isort_ctrl.sv @@
// ----------------------------------------------------------------------------
// isort_ctrl
// load / emit sequencer and handshake control
// ----------------------------------------------------------------------------
module isort_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     set_end,
    input  logic                     out_ready,
    input  isort_pkg::isort_status_t status,
    output logic                     in_ready,
    output logic                     out_valid,
    output isort_pkg::isort_cmd_t    cmd
);
    import isort_pkg::*;

    isort_state_t state_reg;
    isort_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && set_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && status.last_entry)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.insert = 1'b0;
        cmd.pop    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready   = 1'b1;
                cmd.insert = in_valid;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.pop   = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/isort_dp.sv @@
// ----------------------------------------------------------------------------
// isort_dp
// row of compare-and-shift cells with fill count and overflow flag
// ----------------------------------------------------------------------------
module isort_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  isort_pkg::isort_cmd_t    cmd,
    input  isort_pkg::data_t         value,
    output isort_pkg::isort_status_t status,
    output isort_pkg::data_t         sorted_value,
    output logic                     final_result,
    output logic                     dropped
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    data_t            cell_reg  [CAPACITY];
    data_t            cell_next [CAPACITY];
    logic             above     [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             full;

    assign full = (count_reg == CNT_FULL);

    // each cell: empty or holding a larger word means the new word lands at or below it
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            above[i] = (CNT_W'(i) >= count_reg) || (cell_reg[i] > value);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.pop)
            begin
                if (i < CAPACITY - 1)
                begin
                    cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
            else if (cmd.insert && !full && above[i])
            begin
                if (i > 0 && above[(i > 0) ? i - 1 : 0])
                begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end
                else
                begin
                    cell_next[i] = value;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.pop)
        begin
            count_next = count_reg - CNT_ONE;
            if (count_reg == CNT_ONE)
            begin
                ovf_next = 1'b0;
            end
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign sorted_value      = cell_reg[0];
    assign final_result      = (count_reg == CNT_ONE);
    assign dropped           = ovf_reg;
    assign status.last_entry = (count_reg == CNT_ONE);

endmodule

@@ rtl/insertion_sorter_top.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_top
// streaming insertion sorter for signed 32-bit words
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            payload
//  -------   ---   ------------------   ------------------------------------
//  input     in    in_valid/in_ready    value[31:0], set_end
//  output    out   out_valid/out_ready  sorted_value[31:0], final_result,
//                                       dropped
//
//  loading takes words back to back: every cell compares its word with the
//  incoming one in parallel and shifts up or captures in the same edge
//  emission gives one word per cycle while out_ready is high, taken from the
//  head cell while the row shifts down; input is held off during emission
//  reset clears the fill count, overflow flag and controller; cells need none
//  a stall on the output simply holds the head cell and the row
//
module insertion_sorter_top #(
    parameter int CAPACITY = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // input channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      value,
    input  logic                    set_end,
    // output channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      sorted_value,
    output logic                    final_result,
    output logic                    dropped
);
    import isort_pkg::*;

    isort_cmd_t    cmd;
    isort_status_t status;

    // sequencer: load state accepts words, emit state drains the set
    isort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .set_end   (set_end),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // cell row holds the set in ascending order, head at cell zero
    isort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .status       (status),
        .sorted_value (sorted_value),
        .final_result (final_result),
        .dropped      (dropped)
    );

endmodule

@@ rtl/isort_checker.sv @@
// ----------------------------------------------------------------------------
// isort_checker
// port-level checks for the insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
module isort_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        set_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] sorted_value,
    input logic        final_result,
    input logic        dropped
);

    // loading and emission never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during emission");

    // closing word of a set starts emission
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && set_end) |=> out_valid)
        else $error("no emission after set end");

    // final word returns the block to loading
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_result) |=> (!out_valid && in_ready))
        else $error("emission did not end after final word");

    // overflow flag is the same on every word of a set
    a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !final_result) |=> (dropped == $past(dropped)))
        else $error("dropped flag changed within a set");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sorted_value)))
        else $error("output word changed while stalled");

endmodule

bind insertion_sorter_top isort_checker u_isort_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .set_end      (set_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .final_result (final_result),
    .dropped      (dropped)
);
